FILE: rtl/cpq_pkg.sv
// Shared types, widths and operation codes for the two-class priority queue.
package cpq_pkg;

  // Default number of slots shared by both classes.
  localparam int CAPACITY_DEF = 64;

  // Fixed payload widths.
  localparam int FUNC_W = 3;
  localparam int KEY_W  = 30;
  localparam int REC_W  = 32;

  // Operation codes carried on the func field.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ENQ_REG  = 3'd0,
    FUNC_ENQ_CRIT = 3'd1,
    FUNC_DEQ      = 3'd2,
    FUNC_PEEK     = 3'd3,
    FUNC_REMOVE   = 3'd4
  } func_t;

  // Command bundle from the sequencer to the slot memories.
  typedef struct packed {
    logic rd;
    logic data_we;
    logic next_we;
  } slot_cmd_t;

  // Result of one operation, without the occupancy figures.
  typedef struct packed {
    logic             ok;
    logic [KEY_W-1:0] key;
    logic [REC_W-1:0] rec;
    logic             crit;
  } result_t;

endpackage

FILE: rtl/cpq_slot_mem.sv
// Slot storage: a key and record memory and a link memory, each with a registered read.
module cpq_slot_mem #(
  parameter  int CAPACITY = cpq_pkg::CAPACITY_DEF,
  localparam int IW       = $clog2(CAPACITY + 1),
  localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                     clk,
  input  cpq_pkg::slot_cmd_t       cmd,
  input  logic [AW-1:0]            rd_addr,
  input  logic [AW-1:0]            wr_addr,
  input  logic [cpq_pkg::KEY_W-1:0] wr_key,
  input  logic [cpq_pkg::REC_W-1:0] wr_rec,
  input  logic [IW-1:0]            wr_next,
  output logic [cpq_pkg::KEY_W-1:0] rd_key,
  output logic [cpq_pkg::REC_W-1:0] rd_rec,
  output logic [IW-1:0]            rd_next
);

  localparam int DW = cpq_pkg::KEY_W + cpq_pkg::REC_W;

  logic [DW-1:0] data_mem [CAPACITY];
  logic [IW-1:0] next_mem [CAPACITY];

  // Key and record memory: one write and one read port.
  always_ff @(posedge clk) begin
    if (cmd.data_we) begin
      data_mem[wr_addr] <= {wr_key, wr_rec};
    end
    if (cmd.rd) begin
      {rd_key, rd_rec} <= data_mem[rd_addr];
    end
  end

  // Link memory: holds the next slot of each class list and of the free list.
  always_ff @(posedge clk) begin
    if (cmd.next_we) begin
      next_mem[wr_addr] <= wr_next;
    end
    if (cmd.rd) begin
      rd_next <= next_mem[rd_addr];
    end
  end

endmodule

FILE: rtl/cpq_ctrl.sv
// Operation sequencer: list pointers, free-slot pool, occupancy and the list walk.
module cpq_ctrl #(
  parameter  int CAPACITY = cpq_pkg::CAPACITY_DEF,
  localparam int IW       = $clog2(CAPACITY + 1),
  localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [cpq_pkg::FUNC_W-1:0] func,
  input  logic [cpq_pkg::KEY_W-1:0] patient_key,
  input  logic [cpq_pkg::REC_W-1:0] patient_record,
  output cpq_pkg::slot_cmd_t        mem_cmd,
  output logic [AW-1:0]             mem_rd_addr,
  output logic [AW-1:0]             mem_wr_addr,
  output logic [cpq_pkg::KEY_W-1:0] mem_wr_key,
  output logic [cpq_pkg::REC_W-1:0] mem_wr_rec,
  output logic [IW-1:0]             mem_wr_next,
  input  logic [cpq_pkg::KEY_W-1:0] mem_rd_key,
  input  logic [cpq_pkg::REC_W-1:0] mem_rd_rec,
  input  logic [IW-1:0]             mem_rd_next,
  output cpq_pkg::result_t          res,
  output logic                      res_valid,
  input  logic                      res_ready,
  output logic [IW-1:0]             count
);

  localparam logic [IW-1:0] NIL = IW'(CAPACITY);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_ENQ_POP  = 8'b0000_0010,
    S_ENQ_LINK = 8'b0000_0100,
    S_ENQ_TAIL = 8'b0000_1000,
    S_HEAD     = 8'b0001_0000,
    S_WALK     = 8'b0010_0000,
    S_FREE     = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  logic [cpq_pkg::FUNC_W-1:0] func_q;
  logic [cpq_pkg::KEY_W-1:0]  key_q;
  logic [cpq_pkg::REC_W-1:0]  rec_q;
  logic [IW-1:0] crit_head, crit_tail, reg_head, reg_tail;
  logic [IW-1:0] free_head, fill;
  logic [IW-1:0] cur, prev;
  logic          cls;

  logic          accept, is_enq, is_search, is_full_now;
  logic [IW-1:0] cls_tail, pick_slot;
  logic          pick_crit, pick_any, key_hit;

  // Decode of the incoming item and of the current list.
  assign accept      = in_valid && (state == S_IDLE);
  assign in_stall    = (state != S_IDLE);
  assign is_enq      = (func == cpq_pkg::FUNC_ENQ_REG) || (func == cpq_pkg::FUNC_ENQ_CRIT);
  assign is_search   = (func == cpq_pkg::FUNC_DEQ) || (func == cpq_pkg::FUNC_PEEK) ||
                       (func == cpq_pkg::FUNC_REMOVE);
  assign is_full_now = (count == NIL);
  assign cls_tail    = cls ? crit_tail : reg_tail;
  assign pick_crit   = (crit_head != NIL);
  assign pick_any    = pick_crit || (reg_head != NIL);
  assign pick_slot   = pick_crit ? crit_head : reg_head;
  assign key_hit     = (mem_rd_key == key_q);
  assign mem_wr_key  = key_q;
  assign mem_wr_rec  = rec_q;
  assign res_valid   = (state == S_DONE);

  // Memory commands and next state.
  always_comb begin
    mem_cmd     = '0;
    mem_rd_addr = cur[AW-1:0];
    mem_wr_addr = cur[AW-1:0];
    mem_wr_next = NIL;
    state_next  = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority if (is_enq) begin
            priority if (is_full_now) begin
              state_next = S_DONE;
            end else if (free_head != NIL) begin
              mem_cmd.rd  = 1'b1;
              mem_rd_addr = free_head[AW-1:0];
              state_next  = S_ENQ_POP;
            end else begin
              state_next = S_ENQ_LINK;
            end
          end else if (is_search && pick_any) begin
            mem_cmd.rd  = 1'b1;
            mem_rd_addr = pick_slot[AW-1:0];
            state_next  = (func == cpq_pkg::FUNC_REMOVE) ? S_WALK : S_HEAD;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_ENQ_POP: begin
        state_next = S_ENQ_LINK;
      end
      S_ENQ_LINK: begin
        mem_cmd.data_we = 1'b1;
        mem_cmd.next_we = 1'b1;
        state_next      = (cls_tail != NIL) ? S_ENQ_TAIL : S_DONE;
      end
      S_ENQ_TAIL: begin
        mem_cmd.next_we = 1'b1;
        mem_wr_addr     = cls_tail[AW-1:0];
        mem_wr_next     = cur;
        state_next      = S_DONE;
      end
      S_HEAD: begin
        // A dequeue returns the slot to the free list.
        if (func_q == cpq_pkg::FUNC_DEQ) begin
          mem_cmd.next_we = 1'b1;
          mem_wr_next     = free_head;
        end
        state_next = S_DONE;
      end
      S_WALK: begin
        priority if (key_hit) begin
          if (prev != NIL) begin
            mem_cmd.next_we = 1'b1;
            mem_wr_addr     = prev[AW-1:0];
            mem_wr_next     = mem_rd_next;
          end
          state_next = S_FREE;
        end else if (mem_rd_next != NIL) begin
          mem_cmd.rd  = 1'b1;
          mem_rd_addr = mem_rd_next[AW-1:0];
        end else if (cls && (reg_head != NIL)) begin
          mem_cmd.rd  = 1'b1;
          mem_rd_addr = reg_head[AW-1:0];
        end else begin
          state_next = S_DONE;
        end
      end
      S_FREE: begin
        mem_cmd.next_we = 1'b1;
        mem_wr_next     = free_head;
        state_next      = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State, list pointers, free pool and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      crit_head <= NIL;
      crit_tail <= NIL;
      reg_head  <= NIL;
      reg_tail  <= NIL;
      free_head <= NIL;
      fill      <= '0;
      count     <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            func_q <= func;
            key_q  <= patient_key;
            rec_q  <= patient_record;
            res    <= '0;
            prev   <= NIL;
            if (is_enq) begin
              cls <= (func == cpq_pkg::FUNC_ENQ_CRIT);
              if (!is_full_now) begin
                if (free_head != NIL) begin
                  cur <= free_head;
                end else begin
                  cur  <= fill;
                  fill <= fill + 1'b1;
                end
              end
            end else begin
              cls <= pick_crit;
              cur <= pick_slot;
            end
          end
        end
        S_ENQ_POP: begin
          free_head <= mem_rd_next;
        end
        S_ENQ_LINK: begin
          if (cls_tail == NIL) begin
            if (cls) begin
              crit_head <= cur;
              crit_tail <= cur;
            end else begin
              reg_head <= cur;
              reg_tail <= cur;
            end
            count  <= count + 1'b1;
            res.ok <= 1'b1;
          end
        end
        S_ENQ_TAIL: begin
          if (cls) begin
            crit_tail <= cur;
          end else begin
            reg_tail <= cur;
          end
          count  <= count + 1'b1;
          res.ok <= 1'b1;
        end
        S_HEAD: begin
          res.ok   <= 1'b1;
          res.key  <= mem_rd_key;
          res.rec  <= mem_rd_rec;
          res.crit <= cls;
          if (func_q == cpq_pkg::FUNC_DEQ) begin
            if (cls) begin
              crit_head <= mem_rd_next;
              if (mem_rd_next == NIL) begin
                crit_tail <= NIL;
              end
            end else begin
              reg_head <= mem_rd_next;
              if (mem_rd_next == NIL) begin
                reg_tail <= NIL;
              end
            end
            free_head <= cur;
            count     <= count - 1'b1;
          end
        end
        S_WALK: begin
          priority if (key_hit) begin
            res.ok   <= 1'b1;
            res.key  <= mem_rd_key;
            res.rec  <= mem_rd_rec;
            res.crit <= cls;
            if (cls) begin
              if (prev == NIL) begin
                crit_head <= mem_rd_next;
              end
              if (crit_tail == cur) begin
                crit_tail <= prev;
              end
            end else begin
              if (prev == NIL) begin
                reg_head <= mem_rd_next;
              end
              if (reg_tail == cur) begin
                reg_tail <= prev;
              end
            end
            count <= count - 1'b1;
          end else if (mem_rd_next != NIL) begin
            prev <= cur;
            cur  <= mem_rd_next;
          end else if (cls && (reg_head != NIL)) begin
            // Critical list exhausted: carry on with the regular list.
            cls  <= 1'b0;
            prev <= NIL;
            cur  <= reg_head;
          end else begin
            res <= '0;
          end
        end
        S_FREE: begin
          free_head <= cur;
        end
        S_DONE: begin
          res <= res;
        end
        default: begin
          res <= '0;
        end
      endcase
    end
  end

endmodule

FILE: rtl/two_class_priority_queue_remove_by_key_unit.sv
// Top level of the two-class priority queue with remove-by-key.
// The queue holds up to CAPACITY entries in two FIFO classes, critical and regular, which
// share one pool of slots kept in a key/record memory and a link memory, each with a
// registered read port. One item is worked on at a time. An enqueue pops the free list when
// a slot is reused, writes the new slot and links it to the tail when the class already
// holds entries; dequeue and peek read the head of the critical list, else of the regular
// list; remove-by-key walks the critical list and then the regular list entry by entry and
// frees a match; an enqueue into a full queue, a dequeue, peek or removal on an empty queue
// and an unused operation code go straight to the result. The list walk reads one slot per
// cycle through the single read port of the slot memories, and link updates go one at a
// time through the link memory's write port. The next item is taken in the cycle after the
// result has moved into the output register, which holds it while the consumer stalls. No
// clearing pass is needed after reset.
module two_class_priority_queue_remove_by_key_unit #(
  parameter  int CAPACITY = cpq_pkg::CAPACITY_DEF,
  localparam int IW       = $clog2(CAPACITY + 1),
  localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [cpq_pkg::FUNC_W-1:0] func,
  input  logic [cpq_pkg::KEY_W-1:0] patient_key,
  input  logic [cpq_pkg::REC_W-1:0] patient_record,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      ok,
  output logic [cpq_pkg::KEY_W-1:0] out_key,
  output logic [cpq_pkg::REC_W-1:0] out_record,
  output logic                      out_critical,
  output logic [IW-1:0]             occupancy,
  output logic                      is_full
);

  cpq_pkg::slot_cmd_t        mem_cmd;
  logic [AW-1:0]             mem_rd_addr, mem_wr_addr;
  logic [cpq_pkg::KEY_W-1:0] mem_wr_key, mem_rd_key;
  logic [cpq_pkg::REC_W-1:0] mem_wr_rec, mem_rd_rec;
  logic [IW-1:0]             mem_wr_next, mem_rd_next;
  cpq_pkg::result_t          res;
  logic                      res_valid, res_ready;
  logic [IW-1:0]             count;

  cpq_slot_mem #(.CAPACITY(CAPACITY)) u_slot_mem (
    .clk     (clk),
    .cmd     (mem_cmd),
    .rd_addr (mem_rd_addr),
    .wr_addr (mem_wr_addr),
    .wr_key  (mem_wr_key),
    .wr_rec  (mem_wr_rec),
    .wr_next (mem_wr_next),
    .rd_key  (mem_rd_key),
    .rd_rec  (mem_rd_rec),
    .rd_next (mem_rd_next)
  );

  cpq_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .patient_key    (patient_key),
    .patient_record (patient_record),
    .mem_cmd        (mem_cmd),
    .mem_rd_addr    (mem_rd_addr),
    .mem_wr_addr    (mem_wr_addr),
    .mem_wr_key     (mem_wr_key),
    .mem_wr_rec     (mem_wr_rec),
    .mem_wr_next    (mem_wr_next),
    .mem_rd_key     (mem_rd_key),
    .mem_rd_rec     (mem_rd_rec),
    .mem_rd_next    (mem_rd_next),
    .res            (res),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .count          (count)
  );

  // The output register takes a new result when empty or when its content is transferred.
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      ok           <= res.ok;
      out_key      <= res.key;
      out_record   <= res.rec;
      out_critical <= res.crit;
      occupancy    <= count;
      is_full      <= (count == IW'(CAPACITY));
    end
  end

endmodule

FILE: rtl/cpq_checker.sv
// Port-level checks on the priority queue, bound to its top level.
module cpq_checker #(
  parameter  int CAPACITY = cpq_pkg::CAPACITY_DEF,
  localparam int IW       = $clog2(CAPACITY + 1)
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      ok,
  input logic [cpq_pkg::KEY_W-1:0] out_key,
  input logic [cpq_pkg::REC_W-1:0] out_record,
  input logic                      out_critical,
  input logic [IW-1:0]             occupancy,
  input logic                      is_full
);

  localparam logic [IW-1:0] CAP = IW'(CAPACITY);

  // The full flag agrees with the reported occupancy.
  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_full == (occupancy == CAP)))
    else $error("full flag disagrees with occupancy");

  // Occupancy never exceeds the capacity.
  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (occupancy <= CAP))
    else $error("occupancy beyond capacity");

  // A failed operation returns no entry.
  a_fail_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ok) |-> ((out_key == '0) && (out_record == '0) && !out_critical))
    else $error("failed operation returned entry data");

  // Items are worked on one at a time: a transfer in closes the input for the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item taken while one is in progress");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable({ok, out_key, out_record, out_critical, occupancy, is_full})))
    else $error("stalled result changed");

endmodule

bind two_class_priority_queue_remove_by_key_unit cpq_checker #(.CAPACITY(CAPACITY)) u_cpq_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .ok           (ok),
  .out_key      (out_key),
  .out_record   (out_record),
  .out_critical (out_critical),
  .occupancy    (occupancy),
  .is_full      (is_full)
);

FILE: tb/testbench.sv
// Self-checking testbench for the two-class priority queue with remove-by-key.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cpq_pkg::*;

  localparam int CAP       = CAPACITY_DEF;
  localparam int OCC_W     = $clog2(CAP + 1);
  localparam int NIL       = CAP;
  localparam int REGULAR   = 0;
  localparam int CRITICAL  = 1;
  localparam int FUNC_LAST = (1 << FUNC_W) - 1;
  localparam int KEY_MAX   = 999999999;
  localparam int KEY_POOL  = 24;
  localparam int RANDOM_ITEMS = 1450;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 100;
  localparam int REPORT_LINES = 100;

  // Mixes of operations used by the random part of the run.
  typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} op_mix_t;

  // One result as the block reports it.
  typedef struct packed {
    logic             ok;
    logic [KEY_W-1:0] key;
    logic [REC_W-1:0] rec;
    logic             crit;
    logic [OCC_W-1:0] occ;
    logic             full;
  } outcome_t;

  // Shadow copy of the queue, and the results that it predicts.
  class queue_shadow;
    logic [KEY_W-1:0] slot_key [CAP];
    logic [REC_W-1:0] slot_rec [CAP];
    int               slot_link [CAP];
    bit               slot_free [CAP];
    int               list_head [2];
    int               list_tail [2];
    int               held;
    outcome_t         pending_results [$];
    int               mismatches;

    function new();
      for (int i = 0; i < CAP; i++) begin
        slot_key[i]  = '0;
        slot_rec[i]  = '0;
        slot_link[i] = 0;
        slot_free[i] = 1'b1;
      end
      list_head[REGULAR]  = NIL;
      list_tail[REGULAR]  = NIL;
      list_head[CRITICAL] = NIL;
      list_tail[CRITICAL] = NIL;
      held       = 0;
      mismatches = 0;
    endfunction

    task report(string msg);
      if (mismatches < REPORT_LINES)
        $display("%0t ns: mismatch: %s", $time, msg);
      mismatches++;
    endtask

    function int outstanding();
      return pending_results.size();
    endfunction

    function int first_free();
      for (int i = 0; i < CAP; i++)
        if (slot_free[i])
          return i;
      return NIL;
    endfunction

    // Append an entry to the tail of one class.
    function bit append(int cls, logic [KEY_W-1:0] key, logic [REC_W-1:0] rec);
      int s;
      if (held >= CAP)
        return 1'b0;
      s = first_free();
      if (s >= NIL)
        return 1'b0;
      slot_free[s] = 1'b0;
      slot_key[s]  = key;
      slot_rec[s]  = rec;
      slot_link[s] = NIL;
      if (list_tail[cls] < NIL)
        slot_link[list_tail[cls]] = s;
      else
        list_head[cls] = s;
      list_tail[cls] = s;
      held++;
      return 1'b1;
    endfunction

    // Walk one class in order and unlink the first entry with a matching key.
    function bit unlink_key(int cls, logic [KEY_W-1:0] key,
                            output logic [KEY_W-1:0] got_key,
                            output logic [REC_W-1:0] got_rec);
      int prev;
      int cur;
      got_key = '0;
      got_rec = '0;
      prev = NIL;
      cur  = list_head[cls];
      for (int steps = 0; steps < CAP && cur < NIL; steps++) begin
        if (slot_key[cur] == key) begin
          got_key = slot_key[cur];
          got_rec = slot_rec[cur];
          if (prev < NIL)
            slot_link[prev] = slot_link[cur];
          else
            list_head[cls] = slot_link[cur];
          if (list_tail[cls] == cur)
            list_tail[cls] = prev;
          slot_free[cur] = 1'b1;
          if (held > 0)
            held--;
          return 1'b1;
        end
        prev = cur;
        cur  = slot_link[cur];
      end
      return 1'b0;
    endfunction

    // Apply one accepted request to the shadow and queue up its result.
    function void apply_request(logic [FUNC_W-1:0] op, logic [KEY_W-1:0] key,
                                logic [REC_W-1:0] rec);
      outcome_t         e;
      int               src;
      int               s;
      logic [KEY_W-1:0] k;
      logic [REC_W-1:0] r;
      e = '0;
      case (op)
        FUNC_ENQ_REG: begin
          e.ok = append(REGULAR, key, rec);
        end
        FUNC_ENQ_CRIT: begin
          e.ok = append(CRITICAL, key, rec);
        end
        FUNC_DEQ, FUNC_PEEK: begin
          src = (list_head[CRITICAL] < NIL) ? CRITICAL :
                (list_head[REGULAR] < NIL) ? REGULAR : -1;
          if (src >= 0) begin
            s      = list_head[src];
            e.ok   = 1'b1;
            e.key  = slot_key[s];
            e.rec  = slot_rec[s];
            e.crit = (src == CRITICAL);
            if (op == FUNC_DEQ) begin
              list_head[src] = slot_link[s];
              if (list_head[src] >= NIL) begin
                list_head[src] = NIL;
                list_tail[src] = NIL;
              end
              slot_free[s] = 1'b1;
              if (held > 0)
                held--;
            end
          end
        end
        FUNC_REMOVE: begin
          if (unlink_key(CRITICAL, key, k, r)) begin
            e.ok   = 1'b1;
            e.crit = 1'b1;
            e.key  = k;
            e.rec  = r;
          end else if (unlink_key(REGULAR, key, k, r)) begin
            e.ok  = 1'b1;
            e.key = k;
            e.rec = r;
          end
        end
        default: begin
          // Unused codes leave the queue as it is.
        end
      endcase
      e.occ  = OCC_W'(held);
      e.full = (held >= CAP);
      pending_results.push_back(e);
    endfunction

    // Compare one result from the block with the oldest prediction.
    task check_result(outcome_t got);
      outcome_t want;
      if (pending_results.size() == 0) begin
        report("result arrived with nothing predicted");
        return;
      end
      want = pending_results.pop_front();
      if (got.ok !== want.ok)
        report($sformatf("ok: got %0h, expected %0h", got.ok, want.ok));
      if (got.key !== want.key)
        report($sformatf("out_key: got %0h, expected %0h", got.key, want.key));
      if (got.rec !== want.rec)
        report($sformatf("out_record: got %0h, expected %0h", got.rec, want.rec));
      if (got.crit !== want.crit)
        report($sformatf("out_critical: got %0h, expected %0h", got.crit, want.crit));
      if (got.occ !== want.occ)
        report($sformatf("occupancy: got %0d, expected %0d", got.occ, want.occ));
      if (got.full !== want.full)
        report($sformatf("is_full: got %0h, expected %0h", got.full, want.full));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [FUNC_W-1:0] func = '0;
  logic [KEY_W-1:0]  patient_key = '0;
  logic [REC_W-1:0]  patient_record = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              ok;
  logic [KEY_W-1:0]  out_key;
  logic [REC_W-1:0]  out_record;
  logic              out_critical;
  logic [OCC_W-1:0]  occupancy;
  logic              is_full;

  queue_shadow shadow = new();
  int          burst_left = 0;
  int          idle_cycles = 0;

  two_class_priority_queue_remove_by_key_unit #(.CAPACITY(CAP)) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .patient_key    (patient_key),
    .patient_record (patient_record),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .ok             (ok),
    .out_key        (out_key),
    .out_record     (out_record),
    .out_critical   (out_critical),
    .occupancy      (occupancy),
    .is_full        (is_full)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one request and hold it until the transfer; bursts end in a random gap, which may be empty.
  task automatic send_item(input logic [FUNC_W-1:0] op, input logic [KEY_W-1:0] key,
                           input logic [REC_W-1:0] rec);
    int gap;
    @(negedge clk);
    in_valid       <= 1'b1;
    func           <= op;
    patient_key    <= key;
    patient_record <= rec;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    shadow.apply_request(op, key, rec);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if ($urandom_range(0, 19) == 0)
        gap = 30;
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Keys mostly come from a small pool so that duplicates and removal hits are common.
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 85)
      return KEY_W'($urandom_range(0, KEY_POOL - 1));
    return KEY_W'($urandom_range(KEY_MAX, 0));
  endfunction

  // Choose an operation according to the current mix.
  function automatic logic [FUNC_W-1:0] pick_op(op_mix_t mix);
    int enq_w;
    int deq_w;
    int peek_w;
    int roll;
    case (mix)
      MIX_FILL: begin
        enq_w = 75; deq_w = 8; peek_w = 5;
      end
      MIX_BALANCED: begin
        enq_w = 45; deq_w = 20; peek_w = 10;
      end
      default: begin
        enq_w = 15; deq_w = 45; peek_w = 10;
      end
    endcase
    roll = int'($urandom_range(0, 99));
    if (roll < 2)
      return FUNC_W'($urandom_range(FUNC_LAST, FUNC_REMOVE + 1));
    roll -= 2;
    if (roll < enq_w)
      return ($urandom_range(0, 1) == 1) ? FUNC_ENQ_CRIT : FUNC_ENQ_REG;
    roll -= enq_w;
    if (roll < deq_w)
      return FUNC_DEQ;
    roll -= deq_w;
    if (roll < peek_w)
      return FUNC_PEEK;
    return FUNC_REMOVE;
  endfunction

  // Result monitor: every transfer on the output side is checked.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      shadow.check_result({ok, out_key, out_record, out_critical, occupancy, is_full});
  end

  // Receiver back-pressure: runs of free flow, random stalls, alternation and solid holds.
  initial begin
    int run;
    int pct;
    bit toggle;
    forever begin
      run    = $urandom_range(10, 80);
      pct    = 0;
      toggle = 1'b0;
      case ($urandom_range(0, 4))
        0: pct = 0;
        1: pct = 25;
        2: pct = 60;
        3: toggle = 1'b1;
        default: begin
          pct = 100;
          run = $urandom_range(1, 15);
        end
      endcase
      repeat (run) begin
        @(negedge clk);
        if (toggle)
          out_stall <= ~out_stall;
        else
          out_stall <= (int'($urandom_range(0, 99)) < pct);
      end
    end
  end

  // Watchdog: too long without any transfer ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // Main sequence.
  initial begin
    op_mix_t mix;
    int      epoch_len;
    int      sent;
    int      epoch;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: empty queue, extreme fields, priority order, duplicates, unused codes.
    send_item(FUNC_PEEK, '0, '0);
    send_item(FUNC_DEQ, '0, '0);
    send_item(FUNC_REMOVE, KEY_W'(5), '0);
    send_item(FUNC_ENQ_REG, '0, '0);
    send_item(FUNC_ENQ_REG, KEY_W'(KEY_MAX), '1);
    send_item(FUNC_ENQ_CRIT, KEY_W'(7), 32'h0000_1234);
    send_item(FUNC_ENQ_CRIT, KEY_W'(7), 32'hAAAA_5555);
    send_item(FUNC_ENQ_REG, KEY_W'(7), 32'h5555_AAAA);
    send_item(FUNC_PEEK, '0, '0);
    send_item(FUNC_REMOVE, KEY_W'(7), '0);
    send_item(FUNC_REMOVE, KEY_W'(7), '0);
    send_item(FUNC_REMOVE, KEY_W'(7), '0);
    send_item(FUNC_REMOVE, KEY_W'(7), '0);
    for (int f = FUNC_REMOVE + 1; f <= FUNC_LAST; f++)
      send_item(FUNC_W'(f), pick_key(), $urandom());
    send_item(FUNC_REMOVE, KEY_W'(KEY_MAX), '0);
    send_item(FUNC_ENQ_REG, KEY_W'(3), 32'h8000_0001);
    send_item(FUNC_REMOVE, '0, '0);
    send_item(FUNC_DEQ, '0, '0);
    send_item(FUNC_DEQ, '0, '0);
    send_item(FUNC_ENQ_CRIT, KEY_W'(30'h2AAA_AAAA), 32'h5555_5555);
    send_item(FUNC_ENQ_CRIT, KEY_W'(30'h1555_5555), 32'hAAAA_AAAA);
    send_item(FUNC_DEQ, '0, '0);
    send_item(FUNC_DEQ, '0, '0);

    // Random part: epochs in turn that favour filling, churn, and draining.
    sent  = 0;
    epoch = 0;
    while (sent < RANDOM_ITEMS) begin
      mix = op_mix_t'(epoch % 3);
      epoch_len = (mix == MIX_BALANCED) ? $urandom_range(40, 120) : $urandom_range(100, 180);
      for (int i = 0; i < epoch_len && sent < RANDOM_ITEMS; i++) begin
        send_item(pick_op(mix), pick_key(), $urandom());
        sent++;
      end
      epoch++;
    end

    @(negedge clk);
    in_valid <= 1'b0;

    // Wait for every predicted result, then watch for strays.
    while (shadow.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (shadow.mismatches == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule
